[rtl/best_fit_block_allocator_macros.svh]
// ----------------------------------------------------------------------------
// Best-fit block allocator assertion macros
// Short forms for the checks at the end of the allocator module.
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BFA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator check failed");

// Next-cycle implication, disabled during reset.
`define BFA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator check failed");

`endif

[rtl/bfa_pkg.sv]
// ----------------------------------------------------------------------------
// Best-fit block allocator package
// Request kinds, status codes, register indexes and controller states.
// ----------------------------------------------------------------------------
package bfa_pkg;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic CSR_HEAP_BASE  = 1'b0;
   localparam logic CSR_HEAP_LIMIT = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_SPACE   = 2'd1,
      STATUS_TABLE_FULL = 2'd2,
      STATUS_NOT_FOUND  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_PICK,
      ST_FIT,
      ST_PATCH,
      ST_DONE
   } state_type;

endpackage

[rtl/bfa_if.sv]
// ----------------------------------------------------------------------------
// Best-fit block allocator channel interfaces
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface bfa_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [31:0] request_size;
   logic [31:0] block_addr;
   modport source (output valid, func, request_size, block_addr, input ready);
   modport sink   (input valid, func, request_size, block_addr, output ready);
endinterface

interface bfa_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] payload_addr;
   logic [1:0]  status;
   modport source (output valid, payload_addr, status, input ready);
   modport sink   (input valid, payload_addr, status, output ready);
endinterface

interface bfa_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/best_fit_block_allocator.sv]
// ----------------------------------------------------------------------------
// Best-fit block allocator
// Sequential best-fit heap allocator over a block table in one memory.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one transaction per request: func selects allocate or
//   free, request_size is the payload wanted, block_addr the payload to free.
//   rsp_bus returns one transaction per request with payload_addr and status
//   (ok, no space, table full, address not found; address zero on error).
//   csr_bus writes heap_base (index 0) and heap_limit (index 1); it is always
//   ready and must only be used while no request is in flight.
// Timing:
//   One request is handled at a time. Each request walks the block list one
//   entry per cycle through the table memory, whose read data is registered.
//   A finished response waits in the output register; the next request is
//   taken while it waits, and the controller holds its result until the
//   receiver frees the register.
// Reset:
//   Clears the block count, tail pointer and registers (heap_limit 65536).
//   Slots are handed out in order and never released, so the fill count
//   marks which table entries are live; no clearing pass is needed.
// ----------------------------------------------------------------------------
module best_fit_block_allocator
   import bfa_pkg::*;
#(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 16,
   parameter int ADDR_BITS    = 32
) (
   input  logic     clock,
   input  logic     reset,
   bfa_req_if.sink  req_bus,
   bfa_rsp_if.source rsp_bus,
   bfa_csr_if.sink  csr_bus
);

`include "best_fit_block_allocator_macros.svh"

   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int CW = IW + 1;
   // wide enough for header address + header + 32-bit size without wrap
   localparam int WB = ((ADDR_BITS > 32) ? ADDR_BITS : 32) + 2;
   localparam logic [WB-1:0] HDR      = WB'(HEADER_BYTES);
   localparam logic [32:0]   HDR33    = 33'(HEADER_BYTES);
   localparam logic [CW-1:0] CNT_FULL = CW'(MAX_BLOCKS);

   typedef struct packed {
      logic [ADDR_BITS-1:0] base;
      logic [31:0]          size;
      logic                 is_free;
      logic [IW-1:0]        link;
   } entry_type;

   // block table
   entry_type mem [MAX_BLOCKS];
   entry_type rdata_ff;
   logic [IW-1:0] rd_addr;
   logic          wr_en;
   logic [IW-1:0] wr_idx;
   entry_type     wr_data;

   state_type state_ff, state_in;
   logic            func_ff, func_in;
   logic [31:0]     req_ff, req_in;
   logic [31:0]     ptr_ff, ptr_in;
   logic [WB-1:0]   need_ff, need_in;
   logic [IW-1:0]   idx_ff, idx_in;
   logic [IW-1:0]   tail_ff, tail_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            found_ff, found_in;
   logic [IW-1:0]   best_idx_ff, best_idx_in;
   entry_type       best_ff, best_in;
   entry_type       tail_ent_ff, tail_ent_in;
   logic [WB-1:0]   nb_ff, nb_in;
   logic            empty_mode_ff, empty_mode_in;
   entry_type       patch_ff, patch_in;
   logic [IW-1:0]   patch_idx_ff, patch_idx_in;
   logic [31:0]     res_addr_ff, res_addr_in;
   status_type      res_status_ff, res_status_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [31:0]     rsp_addr_ff, rsp_addr_in;
   status_type      rsp_status_ff, rsp_status_in;
   logic [31:0]     heap_base_ff, heap_limit_ff;

   logic            req_fire;
   logic [IW-1:0]   slot;
   logic [31:0]     diff;
   logic [WB-1:0]   lim;
   logic            cand;

   assign req_bus.ready    = (state_ff == ST_IDLE);
   assign req_fire         = req_bus.valid && req_bus.ready;
   assign csr_bus.ready    = 1'b1;
   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.payload_addr = rsp_addr_ff;
   assign rsp_bus.status   = rsp_status_ff;

   assign slot = count_ff[IW-1:0];
   assign lim  = WB'(heap_limit_ff);
   assign diff = best_ff.size - req_ff;
   assign cand = rdata_ff.is_free && (rdata_ff.size >= req_ff) &&
                 (!found_ff || (rdata_ff.size < best_ff.size));

   // follow the link straight from the read data: one entry per cycle
   assign rd_addr = (state_ff == ST_IDLE) ? '0 : rdata_ff.link;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff  <= '0;
         heap_limit_ff <= 32'd65536;
      end else if (csr_bus.valid) begin
         if (csr_bus.index == CSR_HEAP_BASE) begin
            heap_base_ff <= csr_bus.data;
         end else begin
            heap_limit_ff <= csr_bus.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff       <= func_in;
      req_ff        <= req_in;
      ptr_ff        <= ptr_in;
      need_ff       <= need_in;
      idx_ff        <= idx_in;
      found_ff      <= found_in;
      best_idx_ff   <= best_idx_in;
      best_ff       <= best_in;
      tail_ent_ff   <= tail_ent_in;
      nb_ff         <= nb_in;
      empty_mode_ff <= empty_mode_in;
      patch_ff      <= patch_in;
      patch_idx_ff  <= patch_idx_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      req_in        = req_ff;
      ptr_in        = ptr_ff;
      need_in       = need_ff;
      idx_in        = idx_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_in       = best_ff;
      tail_ent_in   = tail_ent_ff;
      nb_in         = nb_ff;
      empty_mode_in = empty_mode_ff;
      patch_in      = patch_ff;
      patch_idx_in  = patch_idx_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_idx        = slot;
      wr_data       = patch_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               func_in       = req_bus.func;
               req_in        = req_bus.request_size;
               ptr_in        = req_bus.block_addr;
               need_in       = WB'(req_bus.request_size) + HDR;
               found_in      = 1'b0;
               idx_in        = '0;
               empty_mode_in = (count_ff == '0);
               if (count_ff == '0) begin
                  if (req_bus.func == FUNC_FREE) begin
                     res_addr_in   = '0;
                     res_status_in = STATUS_NOT_FOUND;
                     state_in      = ST_DONE;
                  end else begin
                     nb_in    = WB'(heap_base_ff);
                     state_in = ST_FIT;
                  end
               end else begin
                  state_in = ST_WALK;
               end
            end
         end

         ST_WALK: begin
            idx_in = rdata_ff.link;
            if (func_ff == FUNC_FREE) begin
               if (WB'(rdata_ff.base) + HDR == WB'(ptr_ff)) begin
                  patch_in         = rdata_ff;
                  patch_in.is_free = 1'b1;
                  patch_idx_in     = idx_ff;
                  res_addr_in      = ptr_ff;
                  res_status_in    = STATUS_OK;
                  state_in         = ST_PATCH;
               end else if (idx_ff == tail_ff) begin
                  res_addr_in   = '0;
                  res_status_in = STATUS_NOT_FOUND;
                  state_in      = ST_DONE;
               end
            end else begin
               if (cand) begin
                  found_in    = 1'b1;
                  best_in     = rdata_ff;
                  best_idx_in = idx_ff;
               end
               if (idx_ff == tail_ff) begin
                  tail_ent_in = rdata_ff;
                  nb_in       = WB'(rdata_ff.base) + HDR + WB'(rdata_ff.size);
                  state_in    = ST_PICK;
               end
            end
         end

         ST_PICK: begin
            if (found_ff) begin
               res_addr_in      = 32'(WB'(best_ff.base) + HDR);
               res_status_in    = STATUS_OK;
               patch_in         = best_ff;
               patch_in.is_free = 1'b0;
               patch_idx_in     = best_idx_ff;
               state_in         = ST_PATCH;
               // split off a free remainder when it can hold a header and a slot is free
               if (({1'b0, diff} >= HDR33) && (count_ff != CNT_FULL)) begin
                  wr_en           = 1'b1;
                  wr_idx          = slot;
                  wr_data.base    = ADDR_BITS'(WB'(best_ff.base) + HDR + WB'(req_ff));
                  wr_data.size    = diff - 32'(HEADER_BYTES);
                  wr_data.is_free = 1'b1;
                  wr_data.link    = (best_idx_ff == tail_ff) ? slot : best_ff.link;
                  patch_in.size   = req_ff;
                  patch_in.link   = slot;
                  count_in        = count_ff + 1'b1;
                  if (best_idx_ff == tail_ff) begin
                     tail_in = slot;
                  end
               end
            end else if (count_ff == CNT_FULL) begin
               res_addr_in   = '0;
               res_status_in = STATUS_TABLE_FULL;
               state_in      = ST_DONE;
            end else begin
               state_in = ST_FIT;
            end
         end

         ST_FIT: begin
            if ((nb_ff <= lim) && (need_ff <= lim - nb_ff)) begin
               wr_en           = 1'b1;
               wr_idx          = slot;
               wr_data.base    = nb_ff[ADDR_BITS-1:0];
               wr_data.size    = req_ff;
               wr_data.is_free = 1'b0;
               wr_data.link    = slot;
               count_in        = count_ff + 1'b1;
               tail_in         = slot;
               res_addr_in     = 32'(WB'(nb_ff[ADDR_BITS-1:0]) + HDR);
               res_status_in   = STATUS_OK;
               if (empty_mode_ff) begin
                  state_in = ST_DONE;
               end else begin
                  patch_in      = tail_ent_ff;
                  patch_in.link = slot;
                  patch_idx_in  = tail_ff;
                  state_in      = ST_PATCH;
               end
            end else begin
               res_addr_in   = '0;
               res_status_in = STATUS_NO_SPACE;
               state_in      = ST_DONE;
            end
         end

         ST_PATCH: begin
            wr_en    = 1'b1;
            wr_idx   = patch_idx_ff;
            wr_data  = patch_ff;
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `BFA_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_FULL)
   `BFA_ASSERT_IMP(a_tail_live, clock, reset, count_ff != '0, CW'(tail_ff) < count_ff)
   `BFA_ASSERT_IMP(a_err_zero, clock, reset,
      rsp_valid_ff && (rsp_status_ff != STATUS_OK), rsp_addr_ff == '0)
   `BFA_ASSERT_NXT(a_count_step, clock, reset, 1'b1,
      (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + 1'b1))

endmodule
